// ----- rtl/lqd_pkg.sv -----
// shared constants and types for the link queue delay model
package lqd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QUEUE_W   = 48;
    localparam int SUM_W     = QUEUE_W + 1;
    localparam int LEN_W     = 17;
    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam int MUL_W     = 32;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    localparam logic [31:0] SAMPLE_MS  = 32'd3000;
    localparam logic [9:0]  MS_PER_S   = 10'd1000;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [4:0]  HDR_FULL   = 5'd28;
    localparam logic [4:0]  HDR_PPP    = 5'd15;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RECV  = 2'd1;
    localparam logic [1:0] OP_SEND  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [7:0] CFG_SEND_BW = 8'd0;
    localparam logic [7:0] CFG_RECV_BW = 8'd1;
    localparam logic [7:0] CFG_PPP     = 8'd2;
    localparam logic [7:0] CFG_COMP    = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TMUL,
        ST_TDIV,
        ST_AVG,
        ST_MLEN,
        ST_MDLY,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/lqd_div.sv -----
// restoring divider, one quotient bit per cycle
module lqd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lqd_pkg::DIV_NUM_W-1:0] num,
    input  logic [lqd_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [lqd_pkg::DIV_NUM_W-1:0] quo
);

    logic [lqd_pkg::DIV_NUM_W-1:0] num_reg;
    logic [lqd_pkg::DIV_DEN_W-1:0] den_reg;
    logic [lqd_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [lqd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [lqd_pkg::DIV_DEN_W+1:0] diff;

    // trial subtract of the divisor from the shifted remainder
    assign diff = {1'b0, rem_reg, num_reg[lqd_pkg::DIV_NUM_W-1]} - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lqd_pkg::DIV_CNT_W'(lqd_pkg::DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[lqd_pkg::DIV_NUM_W-2:0], ~diff[lqd_pkg::DIV_DEN_W+1]};
            if (!diff[lqd_pkg::DIV_DEN_W+1]) begin
                rem_reg <= diff[lqd_pkg::DIV_DEN_W-1:0];
            end else begin
                rem_reg <= {rem_reg[lqd_pkg::DIV_DEN_W-2:0], num_reg[lqd_pkg::DIV_NUM_W-1]};
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

// ----- rtl/lqd_mul.sv -----
// shift-and-add multiplier, one multiplier bit per cycle
module lqd_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lqd_pkg::MUL_W-1:0]     a,
    input  logic [lqd_pkg::MUL_W-1:0]     b,
    output logic                          done,
    output logic [2*lqd_pkg::MUL_W-1:0]   prod
);

    logic [2*lqd_pkg::MUL_W-1:0]  acc_reg;
    logic [2*lqd_pkg::MUL_W-1:0]  mcand_reg;
    logic [lqd_pkg::MUL_W-1:0]    mplier_reg;
    logic [lqd_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == lqd_pkg::MUL_CNT_W'(lqd_pkg::MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= {{lqd_pkg::MUL_W{1'b0}}, a};
            mplier_reg <= b;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[2*lqd_pkg::MUL_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[lqd_pkg::MUL_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/link_queue_delay_model_core.sv -----
// link queue delay model: two leaky-bucket link queues with rate averaging
//
//  channel | handshake            | payload
//  input   | s_valid / s_ready    | s_op, s_time_ms, s_message_length, s_protocol
//  result  | m_valid / m_ready    | m_delay_ms, m_average_*_rate, m_*_backlog
//  config  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word at a time; a single divider is shared by every step, beside one multiplier
// message: two divider passes (length, then delay)
// tick: a multiply and a divide per queue, two more divides when the averages are refreshed
// reset is synchronous, active low; no clearing pass
// a waiting result is held in the output register while the next word runs
module link_queue_delay_model_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_time_ms,
    input  logic [15:0] s_message_length,
    input  logic        s_protocol,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_delay_ms,
    output logic [31:0] m_average_send_rate,
    output logic [31:0] m_average_receive_rate,
    output logic [31:0] m_send_backlog,
    output logic [31:0] m_receive_backlog,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lqd_pkg::state_t state_reg, state_next;

    logic [31:0] snd_bw_reg, rcv_bw_reg;
    logic        ppp_reg;
    logic [6:0]  comp_reg;

    logic [31:0] time_reg;
    logic [15:0] length_reg;
    logic        proto_reg;
    logic        sel_reg;
    logic        issued_reg;

    logic [lqd_pkg::QUEUE_W-1:0] snd_q_reg, rcv_q_reg;
    logic [31:0] last_tick_reg, last_avg_reg;
    logic [31:0] snd_win_reg, rcv_win_reg;
    logic [31:0] snd_avg_reg, rcv_avg_reg;
    logic [lqd_pkg::LEN_W-1:0] len_reg;
    logic [lqd_pkg::SUM_W-1:0] sum_reg;
    logic [31:0] delay_reg;
    logic        m_valid_reg;
    logic [31:0] m_delay_reg, m_snd_avg_reg, m_rcv_avg_reg, m_snd_bl_reg, m_rcv_bl_reg;

    logic        mul_start, mul_done, div_start, div_done, out_load;
    logic [63:0] mul_prod;
    logic [lqd_pkg::DIV_NUM_W-1:0] div_num, div_quo;
    logic [lqd_pkg::DIV_DEN_W-1:0] div_den;

    logic [31:0] bw_sel, bw_eff, win_sel, avg_sel, dt, interval;
    logic [lqd_pkg::QUEUE_W-1:0] q_sel, drained, q_grown;
    logic [6:0]  keep_pct;
    logic [4:0]  hdr;
    logic [lqd_pkg::LEN_W-1:0] len_hdr;
    logic [23:0] scaled;
    logic [41:0] win_k;
    logic [58:0] sum_k;
    logic [32:0] avg_sum, win_add;
    logic [31:0] win_new;

    assign bw_sel   = sel_reg ? rcv_bw_reg  : snd_bw_reg;
    assign bw_eff   = (bw_sel == 32'd0) ? 32'd1 : bw_sel;
    assign q_sel    = sel_reg ? rcv_q_reg   : snd_q_reg;
    assign win_sel  = sel_reg ? rcv_win_reg : snd_win_reg;
    assign avg_sel  = sel_reg ? rcv_avg_reg : snd_avg_reg;
    assign dt       = time_reg - last_tick_reg;
    assign interval = time_reg - last_avg_reg;

    assign keep_pct = (comp_reg > lqd_pkg::PCT_FULL) ? 7'd0 : lqd_pkg::PCT_FULL - comp_reg;
    assign hdr      = (proto_reg || !ppp_reg) ? lqd_pkg::HDR_FULL : lqd_pkg::HDR_PPP;
    assign len_hdr  = lqd_pkg::LEN_W'(length_reg) + lqd_pkg::LEN_W'(hdr);
    assign scaled   = 24'(keep_pct) * 24'(len_hdr);

    // times 1000 as 1024 - 16 - 8
    assign win_k = {win_sel, 10'd0} - 42'({win_sel, 4'd0}) - 42'({win_sel, 3'd0});
    assign sum_k = {sum_reg, 10'd0} - 59'({sum_reg, 4'd0}) - 59'({sum_reg, 3'd0});

    // drained amount at or above the queue empties it
    assign drained = ((|div_quo[lqd_pkg::DIV_NUM_W-1:lqd_pkg::QUEUE_W])
                      || (div_quo[lqd_pkg::QUEUE_W-1:0] >= q_sel))
                     ? '0 : q_sel - div_quo[lqd_pkg::QUEUE_W-1:0];
    assign q_grown = sum_reg[lqd_pkg::SUM_W-1] ? '1 : sum_reg[lqd_pkg::QUEUE_W-1:0];
    assign avg_sum = {1'b0, avg_sel} + {1'b0, div_quo[31:0]};
    assign win_add = {1'b0, win_sel} + 33'(len_reg);
    assign win_new = win_add[32] ? 32'hFFFF_FFFF : win_add[31:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lqd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == lqd_pkg::OP_TICK) begin
                        state_next = lqd_pkg::ST_TMUL;
                    end else if (s_op == lqd_pkg::OP_RECV || s_op == lqd_pkg::OP_SEND) begin
                        state_next = lqd_pkg::ST_MLEN;
                    end else begin
                        state_next = lqd_pkg::ST_DONE;
                    end
                end
            end
            lqd_pkg::ST_TMUL: begin
                if (mul_done) state_next = lqd_pkg::ST_TDIV;
            end
            lqd_pkg::ST_TDIV: begin
                if (div_done) begin
                    if (!sel_reg) begin
                        state_next = lqd_pkg::ST_TMUL;
                    end else if (interval >= lqd_pkg::SAMPLE_MS) begin
                        state_next = lqd_pkg::ST_AVG;
                    end else begin
                        state_next = lqd_pkg::ST_DONE;
                    end
                end
            end
            lqd_pkg::ST_AVG: begin
                if (div_done && sel_reg) state_next = lqd_pkg::ST_DONE;
            end
            lqd_pkg::ST_MLEN: begin
                if (div_done) state_next = lqd_pkg::ST_MDLY;
            end
            lqd_pkg::ST_MDLY: begin
                if (div_done) state_next = lqd_pkg::ST_DONE;
            end
            lqd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = lqd_pkg::ST_IDLE;
            end
            default: state_next = lqd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        div_num   = '0;
        div_den   = lqd_pkg::DIV_DEN_W'(lqd_pkg::MS_PER_S);
        unique case (state_reg)
            lqd_pkg::ST_IDLE: s_ready = 1'b1;
            lqd_pkg::ST_TMUL: mul_start = !issued_reg;
            lqd_pkg::ST_TDIV: begin
                div_start = !issued_reg;
                div_num   = {mul_prod, 16'd0};
            end
            lqd_pkg::ST_AVG: begin
                div_start = !issued_reg;
                div_num   = lqd_pkg::DIV_NUM_W'(win_k);
                div_den   = lqd_pkg::DIV_DEN_W'(interval);
            end
            lqd_pkg::ST_MLEN: begin
                div_start = !issued_reg;
                div_num   = lqd_pkg::DIV_NUM_W'(scaled);
                div_den   = lqd_pkg::DIV_DEN_W'(lqd_pkg::PCT_FULL);
            end
            lqd_pkg::ST_MDLY: begin
                div_start = !issued_reg;
                div_num   = lqd_pkg::DIV_NUM_W'(sum_k);
                div_den   = {bw_eff, 16'd0};
            end
            lqd_pkg::ST_DONE: out_load = !m_valid_reg || m_ready;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lqd_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            snd_bw_reg    <= 32'hFFFF_FFFF;
            rcv_bw_reg    <= 32'hFFFF_FFFF;
            ppp_reg       <= 1'b1;
            comp_reg      <= '0;
            snd_q_reg     <= '0;
            rcv_q_reg     <= '0;
            last_tick_reg <= '0;
            last_avg_reg  <= '0;
            snd_win_reg   <= '0;
            rcv_win_reg   <= '0;
            snd_avg_reg   <= '0;
            rcv_avg_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end else if (mul_done || div_done) begin
                issued_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    lqd_pkg::CFG_SEND_BW: snd_bw_reg <= cfg_data;
                    lqd_pkg::CFG_RECV_BW: rcv_bw_reg <= cfg_data;
                    lqd_pkg::CFG_PPP:     ppp_reg    <= cfg_data[0];
                    lqd_pkg::CFG_COMP:    comp_reg   <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (div_done) begin
                unique case (state_reg)
                    lqd_pkg::ST_TDIV: begin
                        if (sel_reg) begin
                            rcv_q_reg     <= drained;
                            last_tick_reg <= time_reg;
                        end else begin
                            snd_q_reg <= drained;
                        end
                    end
                    lqd_pkg::ST_AVG: begin
                        if (sel_reg) begin
                            rcv_avg_reg  <= avg_sum[32:1];
                            snd_win_reg  <= '0;
                            rcv_win_reg  <= '0;
                            last_avg_reg <= time_reg;
                        end else begin
                            snd_avg_reg <= avg_sum[32:1];
                        end
                    end
                    lqd_pkg::ST_MDLY: begin
                        if (sel_reg) begin
                            rcv_q_reg   <= q_grown;
                            rcv_win_reg <= win_new;
                        end else begin
                            snd_q_reg   <= q_grown;
                            snd_win_reg <= win_new;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            time_reg   <= s_time_ms;
            length_reg <= s_message_length;
            proto_reg  <= s_protocol;
            sel_reg    <= (s_op == lqd_pkg::OP_RECV);
            delay_reg  <= '0;
        end else if (div_done) begin
            if (state_reg == lqd_pkg::ST_TDIV || state_reg == lqd_pkg::ST_AVG) begin
                sel_reg <= ~sel_reg;
            end
            if (state_reg == lqd_pkg::ST_MLEN) begin
                len_reg <= div_quo[lqd_pkg::LEN_W-1:0];
                sum_reg <= lqd_pkg::SUM_W'({div_quo[lqd_pkg::LEN_W-1:0], 16'd0})
                         + lqd_pkg::SUM_W'(q_sel);
            end
            if (state_reg == lqd_pkg::ST_MDLY) begin
                delay_reg <= (|div_quo[lqd_pkg::DIV_NUM_W-1:32]) ? 32'hFFFF_FFFF
                                                                  : div_quo[31:0];
            end
        end
        if (out_load) begin
            m_delay_reg   <= delay_reg;
            m_snd_avg_reg <= snd_avg_reg;
            m_rcv_avg_reg <= rcv_avg_reg;
            m_snd_bl_reg  <= snd_q_reg[lqd_pkg::QUEUE_W-1:lqd_pkg::FRAC_BITS];
            m_rcv_bl_reg  <= rcv_q_reg[lqd_pkg::QUEUE_W-1:lqd_pkg::FRAC_BITS];
        end
    end

    lqd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (dt),
        .b       (bw_sel),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    lqd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cfg_ready              = 1'b1;
    assign m_valid                = m_valid_reg;
    assign m_delay_ms             = m_delay_reg;
    assign m_average_send_rate    = m_snd_avg_reg;
    assign m_average_receive_rate = m_rcv_avg_reg;
    assign m_send_backlog         = m_snd_bl_reg;
    assign m_receive_backlog      = m_rcv_bl_reg;

`ifndef ASSERT_OFF
    a_mul_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> state_reg == lqd_pkg::ST_TMUL)
        else $error("multiplier started outside drain step");

    a_queue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lqd_pkg::ST_IDLE |=> $stable(snd_q_reg) && $stable(rcv_q_reg))
        else $error("queue changed while idle");

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_start && div_start))
        else $error("both arithmetic units started together");

    a_done_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && state_reg == lqd_pkg::ST_IDLE)
        else $error("result load did not return to idle");
`endif

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the link queue delay model core
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] time_ms;
        logic [15:0] length;
        logic        protocol;
    } word_t;

    typedef struct packed {
        logic [31:0] delay;
        logic [31:0] avg_send;
        logic [31:0] avg_recv;
        logic [31:0] send_backlog;
        logic [31:0] recv_backlog;
    } link_result_t;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = lqd_pkg::OP_TICK;
    logic [31:0] s_time_ms = '0;
    logic [15:0] s_message_length = '0;
    logic        s_protocol = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_delay_ms;
    logic [31:0] m_average_send_rate;
    logic [31:0] m_average_receive_rate;
    logic [31:0] m_send_backlog;
    logic [31:0] m_receive_backlog;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = lqd_pkg::CFG_SEND_BW;
    logic [31:0] cfg_data = '0;

    link_queue_delay_model_core dut (.*);

    always #5 aclk = ~aclk;

    // model copy of the link state and registers
    logic [31:0] send_bw, recv_bw;
    logic        ppp_on;
    logic [6:0]  comp_pct;
    logic [47:0] send_q, recv_q;
    logic [31:0] last_tick, last_avg, win_sent, win_recv, rate_send, rate_recv;

    word_t        pending_words[$];
    link_result_t expected_results[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  hold_sender = 1'b0;
    bit  long_stall_req = 1'b0;
    logic [31:0] clock_ms = 0;

    function automatic logic [47:0] drained(logic [47:0] q, logic [31:0] dt, logic [31:0] bw);
        logic [63:0]  prod;
        logic [63:0]  whole;
        logic [63:0]  rem;
        logic [79:0]  amount;
        prod  = 64'(dt) * 64'(bw);
        whole = prod / 1000;
        rem   = prod % 1000;
        if (whole > 64'hFFFF_FFFF) return '0;
        amount = (80'(whole) << lqd_pkg::FRAC_BITS)
               + ((80'(rem) << lqd_pkg::FRAC_BITS) / 1000);
        if (amount >= 80'(q)) return '0;
        return q - 48'(amount);
    endfunction

    function automatic logic [31:0] smoothed(logic [31:0] old, logic [31:0] win,
                                             logic [31:0] interval);
        logic [63:0] fresh;
        fresh = (64'd1000 * 64'(win)) / 64'(interval);
        return 32'((64'(old) + fresh) >> 1);
    endfunction

    function automatic logic [31:0] message_delay(inout logic [47:0] q,
                                                  inout logic [31:0] win,
                                                  input logic [31:0] bw,
                                                  input logic [15:0] length,
                                                  input logic proto);
        logic [31:0]  hdr, comp, len;
        logic [127:0] num, quo;
        logic [48:0]  grown;
        logic [32:0]  wsum;
        logic [31:0]  delay;
        hdr  = (proto || !ppp_on) ? 28 : 15;
        comp = comp_pct > 100 ? 100 : 32'(comp_pct);
        len  = ((100 - comp) * (32'(length) + hdr)) / 100;
        num  = 128'd1000 * ((128'(len) << lqd_pkg::FRAC_BITS) + 128'(q));
        quo  = num / (128'(bw == 0 ? 32'd1 : bw) << lqd_pkg::FRAC_BITS);
        delay = quo > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(quo);
        grown = 49'(q) + (49'(len) << lqd_pkg::FRAC_BITS);
        q = grown > 49'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : 48'(grown);
        wsum = 33'(win) + 33'(len);
        win = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
        return delay;
    endfunction

    function automatic link_result_t predict_link(word_t w);
        link_result_t r;
        logic [31:0] dt, interval;
        r.delay = '0;
        if (w.op == lqd_pkg::OP_TICK) begin
            dt = w.time_ms - last_tick;
            interval = w.time_ms - last_avg;
            send_q = drained(send_q, dt, send_bw);
            recv_q = drained(recv_q, dt, recv_bw);
            if (interval >= lqd_pkg::SAMPLE_MS) begin
                rate_send = smoothed(rate_send, win_sent, interval);
                rate_recv = smoothed(rate_recv, win_recv, interval);
                win_sent = '0;
                win_recv = '0;
                last_avg = w.time_ms;
            end
            last_tick = w.time_ms;
        end else if (w.op == lqd_pkg::OP_RECV) begin
            r.delay = message_delay(recv_q, win_recv, recv_bw, w.length, w.protocol);
        end else if (w.op == lqd_pkg::OP_SEND) begin
            r.delay = message_delay(send_q, win_sent, send_bw, w.length, w.protocol);
        end
        r.avg_send = rate_send;
        r.avg_recv = rate_recv;
        r.send_backlog = send_q[47:16];
        r.recv_backlog = recv_q[47:16];
        return r;
    endfunction

    // sender: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_link(pending_words[0]));
                void'(pending_words.pop_front());
            end
            if (s_valid && !s_ready) begin
                // hold the word
            end else if (gap_left > 0 || hold_sender || pending_words.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                s_valid <= 1'b1;
                s_op <= pending_words[0].op;
                s_time_ms <= pending_words[0].time_ms;
                s_message_length <= pending_words[0].length;
                s_protocol <= pending_words[0].protocol;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(400, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: its own stall pattern plus a long hold-off on request
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_stall_req && stall_left == 0) begin
            stall_left <= 3000;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(3, 0) != 0) || ($urandom_range(1, 0) == 1);
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    link_result_t e;
                    e = expected_results.pop_front();
                    if (m_delay_ms !== e.delay) begin
                        $error("delay_ms exp %0d got %0d", e.delay, m_delay_ms);
                        fail_count++;
                    end
                    if (m_average_send_rate !== e.avg_send) begin
                        $error("average_send_rate exp %0d got %0d", e.avg_send,
                               m_average_send_rate);
                        fail_count++;
                    end
                    if (m_average_receive_rate !== e.avg_recv) begin
                        $error("average_receive_rate exp %0d got %0d", e.avg_recv,
                               m_average_receive_rate);
                        fail_count++;
                    end
                    if (m_send_backlog !== e.send_backlog) begin
                        $error("send_backlog exp %0d got %0d", e.send_backlog,
                               m_send_backlog);
                        fail_count++;
                    end
                    if (m_receive_backlog !== e.recv_backlog) begin
                        $error("receive_backlog exp %0d got %0d", e.recv_backlog,
                               m_receive_backlog);
                        fail_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("link_queue_delay_model_core verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lqd_pkg::CFG_SEND_BW: send_bw = value;
            lqd_pkg::CFG_RECV_BW: recv_bw = value;
            lqd_pkg::CFG_PPP:     ppp_on = value[0];
            lqd_pkg::CFG_COMP:    comp_pct = value[6:0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    task automatic add_word(logic [1:0] op, logic [31:0] t, logic [15:0] len, logic proto);
        word_t w;
        w.op = op;
        w.time_ms = t;
        w.length = len;
        w.protocol = proto;
        pending_words.push_back(w);
    endtask

    task automatic random_phase(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(9, 0);
            if (pick < 3) begin
                clock_ms = clock_ms + (($urandom_range(9, 0) == 0) ? $urandom :
                                       $urandom_range(4000, 0));
                add_word(lqd_pkg::OP_TICK, clock_ms, 16'($urandom), 1'($urandom));
            end else if (pick == 9 && $urandom_range(3, 0) == 0) begin
                add_word(lqd_pkg::OP_SPARE, $urandom, 16'($urandom), 1'($urandom));
            end else begin
                add_word(pick < 6 ? lqd_pkg::OP_RECV : lqd_pkg::OP_SEND, $urandom,
                         16'(($urandom_range(4, 0) == 0) ? $urandom
                                                         : $urandom_range(1500, 0)),
                         1'($urandom));
            end
        end
    endtask

    initial begin
        send_bw = 32'hFFFF_FFFF;
        recv_bw = 32'hFFFF_FFFF;
        ppp_on = 1'b1;
        comp_pct = '0;
        send_q = '0; recv_q = '0;
        last_tick = '0; last_avg = '0;
        win_sent = '0; win_recv = '0;
        rate_send = '0; rate_recv = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, extremes, every op, odd cases
        add_word(lqd_pkg::OP_SEND, 32'd0, 16'hFFFF, 1'b1);
        add_word(lqd_pkg::OP_RECV, 32'd0, 16'd0, 1'b0);
        add_word(lqd_pkg::OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        add_word(lqd_pkg::OP_TICK, 32'd3000, 16'd0, 1'b0);
        drain_all();
        write_reg(lqd_pkg::CFG_SEND_BW, 32'd1);
        write_reg(lqd_pkg::CFG_RECV_BW, 32'd0);
        write_reg(lqd_pkg::CFG_PPP, 32'd0);
        write_reg(lqd_pkg::CFG_COMP, 32'd127);
        add_word(lqd_pkg::OP_SEND, 32'd0, 16'hFFFF, 1'b0);
        add_word(lqd_pkg::OP_RECV, 32'd0, 16'd100, 1'b1);
        drain_all();
        write_reg(lqd_pkg::CFG_COMP, 32'd0);
        for (int i = 0; i < 6; i++) add_word(lqd_pkg::OP_SEND, 32'd0, 16'hFFFF, i[0]);
        add_word(lqd_pkg::OP_RECV, 32'd0, 16'hFFFF, 1'b0);
        add_word(lqd_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0, 1'b0);
        add_word(lqd_pkg::OP_TICK, 32'd5, 16'd0, 1'b0);
        add_word(lqd_pkg::OP_TICK, 32'd2, 16'd0, 1'b0);
        clock_ms = 2;
        drain_all();

        // long receiver hold-off while the sender keeps offering
        long_stall_req = 1'b1;
        write_reg(lqd_pkg::CFG_SEND_BW, 32'd100_000);
        write_reg(lqd_pkg::CFG_RECV_BW, 32'd20_000);
        write_reg(lqd_pkg::CFG_PPP, 32'd1);
        write_reg(lqd_pkg::CFG_COMP, 32'd30);
        long_stall_req = 1'b0;
        random_phase(120);
        drain_all();

        write_reg(lqd_pkg::CFG_SEND_BW, $urandom_range(1_000_000, 1));
        write_reg(lqd_pkg::CFG_RECV_BW, 32'hFFFF_FFFF);
        write_reg(lqd_pkg::CFG_COMP, 32'd100);
        random_phase(100);
        // sender pauses mid-phase until all results are in
        while (pending_words.size() > 50) @(posedge aclk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0 || s_valid) @(posedge aclk);
        hold_sender = 1'b0;
        drain_all();

        write_reg(lqd_pkg::CFG_SEND_BW, $urandom);
        write_reg(lqd_pkg::CFG_RECV_BW, $urandom_range(5000, 1));
        write_reg(lqd_pkg::CFG_PPP, 32'd0);
        write_reg(lqd_pkg::CFG_COMP, $urandom_range(100, 0));
        random_phase(110);
        drain_all();

        write_reg(lqd_pkg::CFG_SEND_BW, 32'd1000);
        write_reg(lqd_pkg::CFG_PPP, 32'd1);
        write_reg(lqd_pkg::CFG_COMP, 32'd0);
        random_phase(110);
        drain_all();

        if (fail_count == 0)
            $display("link_queue_delay_model_core verification clean");
        else
            $display("link_queue_delay_model_core verification failed");
        $finish;
    end
endmodule
